FILE: src/tse_pkg.sv
// Package for the timestamp extension encoder.
// Holds the beat payload types, the sequencer state type and the size and code helpers.
// No dependencies.
`default_nettype none

package tse_pkg;

   typedef struct packed {
      logic signed [63:0] seconds;
      logic        [31:0] nanoseconds;
      logic signed [15:0] utc_offset_value;
      logic               dst_flag;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_descriptor;
      logic       last_byte;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DESC,
      ST_SEC,
      ST_NSEC,
      ST_OFS_HI,
      ST_OFS_LO
   } tse_state_type;

   localparam logic [7:0]  OFS_PRESENT_CODE = 8'h20;
   localparam logic [15:0] OFS_DST_SET      = 16'hc000;
   localparam logic [15:0] OFS_DST_CLEAR    = 16'h3fff;

   // Fewest two's-complement bytes that hold the value; zero needs none.
   function automatic logic [3:0] signed_size(input logic [63:0] v);
      logic [3:0]  res;
      logic [63:0] top;
      logic [63:0] all_ones;
      res = 4'd8;
      for (int n = 7; n >= 1; n--) begin
         top      = v >> (8 * n - 1);
         all_ones = 64'hffff_ffff_ffff_ffff >> (8 * n - 1);
         if (top == 64'd0 || top == all_ones) begin
            res = 4'(n);
         end
      end
      if (v == 64'd0) begin
         res = 4'd0;
      end
      return res;
   endfunction

   // Fewest unsigned bytes that hold the value; zero needs none.
   function automatic logic [2:0] unsigned_size(input logic [31:0] v);
      logic [2:0] res;
      if (v == 32'd0)             res = 3'd0;
      else if (v[31:8] == 24'd0)  res = 3'd1;
      else if (v[31:16] == 16'd0) res = 3'd2;
      else if (v[31:24] == 8'd0)  res = 3'd3;
      else                        res = 3'd4;
      return res;
   endfunction

   function automatic logic [7:0] sec_code(input logic [3:0] ss);
      logic [7:0] res;
      case (ss)
         4'd0:    res = 8'h00;
         4'd1:    res = 8'h80;
         4'd2:    res = 8'h84;
         4'd3:    res = 8'h88;
         4'd4:    res = 8'h8c;
         4'd5:    res = 8'h90;
         4'd6:    res = 8'h94;
         4'd7:    res = 8'h98;
         default: res = 8'h9c;
      endcase
      return res;
   endfunction

   function automatic logic [7:0] nsec_code(input logic [2:0] ns);
      logic [7:0] res;
      case (ns)
         3'd0:    res = 8'h00;
         3'd1:    res = 8'h40;
         3'd2:    res = 8'h41;
         3'd3:    res = 8'h42;
         default: res = 8'h43;
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

FILE: src/timestamp_ext_encoder_top.sv
// Top level of the timestamp extension encoder.
// Depends on tse_pkg for payload types, the sequencer state type and the code helpers.
`default_nettype none

// The encoder takes one timestamp beat (signed seconds, unsigned nanoseconds, signed UTC
// offset and a DST flag) and returns it as a stream of byte beats: a descriptor byte,
// then the seconds trimmed to their fewest two's-complement bytes, then the nanoseconds
// trimmed to their fewest unsigned bytes, both most significant byte first, and finally
// two offset bytes when the offset is nonzero. The first beat carries is_descriptor and
// the final beat carries last_byte; an all-zero timestamp gives a single descriptor beat
// marked as both. A timestamp is captured and then emitted byte by byte: a single byte
// selector over the held seconds or nanoseconds word produces one byte per cycle under a
// small sequencer while the output stage has room. While a timestamp is being emitted
// req_stall is high. The output is a registered stage, so a stall on the result side
// holds the current byte and pauses the sequencer without losing anything; a new
// timestamp can be captured while the final byte of the previous one still waits to be
// taken.
module timestamp_ext_encoder_top (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_stall,
   input  tse_pkg::req_payload_type  req_data,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output tse_pkg::rsp_payload_type  rsp_data
);
   import tse_pkg::*;

   // Sequencer and byte counters.
   tse_state_type   state_ff, state_in;
   logic [3:0]      emit_count_ff, emit_count_in;
   logic [3:0]      total_bytes_ff, total_bytes_in;
   logic [3:0]      sec_cnt_ff, sec_cnt_in;
   logic [2:0]      nsec_cnt_ff, nsec_cnt_in;
   logic            has_ofs_ff, has_ofs_in;

   // Captured timestamp, held for the whole emission.
   logic [63:0]     sec_ff;
   logic [31:0]     nsec_ff;
   logic [15:0]     ofs_ff, ofs_in;
   logic [7:0]      desc_ff, desc_in;

   // Output register stage.
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic            req_accept;
   logic            room;
   logic            last;
   logic [3:0]      ss_w;
   logic [2:0]      ns_w;
   logic [63:0]     byte_word;
   logic [2:0]      byte_idx;
   logic [7:0]      picked_byte;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // The output stage can take a new byte when it is empty or its byte leaves now.
   assign room = !rsp_valid_ff || !rsp_stall;
   assign last = ((emit_count_ff + 4'd1) == total_bytes_ff);

   // Shared byte selector: picks byte (count - 1) of the seconds or nanoseconds word.
   assign byte_word   = (state_ff == ST_NSEC) ? {32'd0, nsec_ff} : sec_ff;
   assign byte_idx    = (state_ff == ST_NSEC) ? (nsec_cnt_ff - 3'd1) : sec_cnt_ff[2:0] - 3'd1;
   assign picked_byte = byte_word[{byte_idx, 3'b000} +: 8];

   // Size detection and descriptor formation for the incoming timestamp.
   always_comb begin
      ss_w       = signed_size(req_data.seconds);
      ns_w       = unsigned_size(req_data.nanoseconds);
      has_ofs_in = (req_data.utc_offset_value != 16'sd0);
      desc_in    = sec_code(ss_w) | nsec_code(ns_w);
      ofs_in     = req_data.utc_offset_value;
      if (has_ofs_in) begin
         desc_in = desc_in | OFS_PRESENT_CODE;
         ofs_in  = req_data.dst_flag ? (ofs_in | OFS_DST_SET) : (ofs_in & OFS_DST_CLEAR);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         emit_count_ff  <= 4'd0;
         total_bytes_ff <= 4'd0;
         sec_cnt_ff     <= 4'd0;
         nsec_cnt_ff    <= 3'd0;
         has_ofs_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         emit_count_ff  <= emit_count_in;
         total_bytes_ff <= total_bytes_in;
         sec_cnt_ff     <= sec_cnt_in;
         nsec_cnt_ff    <= nsec_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (req_accept) begin
            has_ofs_ff <= has_ofs_in;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (req_accept) begin
         sec_ff  <= req_data.seconds;
         nsec_ff <= req_data.nanoseconds;
         ofs_ff  <= ofs_in;
         desc_ff <= desc_in;
      end
   end

   // Sequencer: next state, counters and the byte presented to the output stage.
   always_comb begin
      state_in       = state_ff;
      emit_count_in  = emit_count_ff;
      total_bytes_in = total_bytes_ff;
      sec_cnt_in     = sec_cnt_ff;
      nsec_cnt_in    = nsec_cnt_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_data_in    = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               sec_cnt_in     = ss_w;
               nsec_cnt_in    = ns_w;
               total_bytes_in = 4'd1 + ss_w + {1'b0, ns_w} + (has_ofs_in ? 4'd2 : 4'd0);
               emit_count_in  = 4'd0;
               state_in       = ST_DESC;
            end
         end
         ST_DESC: begin
            if (room) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.out_byte      = desc_ff;
               rsp_data_in.is_descriptor = 1'b1;
               rsp_data_in.last_byte     = last;
               emit_count_in             = emit_count_ff + 4'd1;
               if (sec_cnt_ff != 4'd0)       state_in = ST_SEC;
               else if (nsec_cnt_ff != 3'd0) state_in = ST_NSEC;
               else if (has_ofs_ff)          state_in = ST_OFS_HI;
               else                          state_in = ST_IDLE;
            end
         end
         ST_SEC: begin
            if (room) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.out_byte      = picked_byte;
               rsp_data_in.is_descriptor = 1'b0;
               rsp_data_in.last_byte     = last;
               emit_count_in             = emit_count_ff + 4'd1;
               sec_cnt_in                = sec_cnt_ff - 4'd1;
               if (sec_cnt_ff == 4'd1) begin
                  if (nsec_cnt_ff != 3'd0) state_in = ST_NSEC;
                  else if (has_ofs_ff)     state_in = ST_OFS_HI;
                  else                     state_in = ST_IDLE;
               end
            end
         end
         ST_NSEC: begin
            if (room) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.out_byte      = picked_byte;
               rsp_data_in.is_descriptor = 1'b0;
               rsp_data_in.last_byte     = last;
               emit_count_in             = emit_count_ff + 4'd1;
               nsec_cnt_in               = nsec_cnt_ff - 3'd1;
               if (nsec_cnt_ff == 3'd1) begin
                  state_in = has_ofs_ff ? ST_OFS_HI : ST_IDLE;
               end
            end
         end
         ST_OFS_HI: begin
            if (room) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.out_byte      = ofs_ff[15:8];
               rsp_data_in.is_descriptor = 1'b0;
               rsp_data_in.last_byte     = 1'b0;
               emit_count_in             = emit_count_ff + 4'd1;
               state_in                  = ST_OFS_LO;
            end
         end
         ST_OFS_LO: begin
            if (room) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.out_byte      = ofs_ff[7:0];
               rsp_data_in.is_descriptor = 1'b0;
               rsp_data_in.last_byte     = 1'b1;
               emit_count_in             = emit_count_ff + 4'd1;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   // A captured timestamp always starts with its descriptor byte.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_DESC))
      else $error("capture did not start descriptor emission");

   // While emitting, the byte count stays below the planned total.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (total_bytes_ff != 4'd0 && emit_count_ff < total_bytes_ff))
      else $error("emitted byte count overran the planned total");

   // Loading the final byte returns the sequencer to idle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && room && last) |=> (state_ff == ST_IDLE))
      else $error("sequencer kept running after the final byte");

   // The descriptor byte is presented only as the first byte of a timestamp.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DESC && room) |-> (emit_count_ff == 4'd0))
      else $error("descriptor byte not first in its timestamp");
`endif

endmodule

`default_nettype wire
